// ----- design/tpi_pkg.sv -----
// tpi_pkg: widths, field layout and shared types of the three-plane intersection
// used by tpi_div and three_plane_intersection; no dependencies
package tpi_pkg;

	// field formats: normals Q2.(NORMAL_BITS-2), offsets and points Q(C/2).(C/2)
	localparam int NORMAL_BITS = 16;
	localparam int COORD_BITS  = 32;
	localparam int FRAC_BITS   = NORMAL_BITS - 2;

	// internal widths, each wide enough for its worst case
	localparam int PROD_W  = 2 * NORMAL_BITS;
	localparam int CROSS_W = PROD_W + 1;
	localparam int DEN_W   = NORMAL_BITS + CROSS_W + 2;
	localparam int SUM_W   = COORD_BITS + CROSS_W + 2;
	localparam int NUM_W   = SUM_W + FRAC_BITS + 1;
	localparam int QUO_W   = COORD_BITS;
	localparam int REM_W   = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;

	// stream layout
	localparam int PLANE_W  = 3 * NORMAL_BITS + COORD_BITS;
	localparam int IN_BITS  = 3 * PLANE_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = 3 * COORD_BITS;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// stages ahead of the divider, and total latency
	localparam int PRE_STAGES = 6;
	localparam int LATENCY    = PRE_STAGES + QUO_W + 1;

	// side information that travels with each quotient
	typedef struct packed {
		logic neg;
		logic ovf;
		logic found;
	} side_t;

endpackage

// ----- design/tpi_div.sv -----
// tpi_div: pipelined restoring divider, one quotient bit per stage
// depends on tpi_pkg
module tpi_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [tpi_pkg::REM_W-1:0]     num_in,
	input  logic [tpi_pkg::DEN_W-1:0]     den_in,
	input  tpi_pkg::side_t                side_in,
	output logic [tpi_pkg::QUO_W-1:0]     quo,
	output tpi_pkg::side_t                side_out
);

	localparam int RW = tpi_pkg::REM_W;
	localparam int DW = tpi_pkg::DEN_W;
	localparam int QW = tpi_pkg::QUO_W;

	logic [RW-1:0]  rem_s  [QW];
	logic [DW-1:0]  den_s  [QW];
	logic [QW-1:0]  quo_s  [QW];
	tpi_pkg::side_t side_s [QW];

	// one compare and subtract per stage, most significant quotient bit first
	for (genvar j = 0; j < QW; j++) begin : g_stage
		logic [RW-1:0]  rem_prev;
		logic [DW-1:0]  den_prev;
		logic [QW-1:0]  quo_prev;
		tpi_pkg::side_t side_prev;
		logic [RW:0]    trial;

		if (j == 0) begin : g_first
			assign rem_prev  = num_in;
			assign den_prev  = den_in;
			assign quo_prev  = '0;
			assign side_prev = side_in;
		end else begin : g_next
			assign rem_prev  = rem_s[j-1];
			assign den_prev  = den_s[j-1];
			assign quo_prev  = quo_s[j-1];
			assign side_prev = side_s[j-1];
		end

		assign trial = {1'b0, rem_prev} - ((RW + 1)'(den_prev) << (QW - 1 - j));

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= trial[RW] ? rem_prev : trial[RW-1:0];
				quo_s[j]  <= {quo_prev[QW-2:0], ~trial[RW]};
				den_s[j]  <= den_prev;
				side_s[j] <= side_prev;
			end
		end
	end

	assign quo      = quo_s[QW-1];
	assign side_out = side_s[QW-1];

endmodule

// ----- design/three_plane_intersection.sv -----
// three_plane_intersection: top level, Cramer's rule over the triple product
// depends on tpi_pkg and tpi_div
//
// Each transfer in carries three planes (normal Q2.14, intercept Q16.16); each
// transfer out carries their common point in Q16.16, rounded to nearest with
// ties away from zero and saturated, plus a found flag that is low, with the
// point at zero, when the normals' triple product is zero. One item is taken
// every cycle unless the pipeline holds; each item passes through six arithmetic
// stages, a 32-stage quotient pipeline and one output register. The whole
// pipeline holds while a result waits and the output side is not ready.
module three_plane_intersection (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// from bit 0: first_normal_x/y/z, first_offset, second_normal_x/y/z,
	// second_offset, third_normal_x/y/z, third_offset
	input  logic [tpi_pkg::IN_W-1:0]      s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// from bit 0: point_x, point_y, point_z
	output logic [tpi_pkg::OUT_W-1:0]     m_axis_tdata,
	// found
	output logic                          m_axis_tuser
);

	localparam int NB  = tpi_pkg::NORMAL_BITS;
	localparam int CB  = tpi_pkg::COORD_BITS;
	localparam int PW  = tpi_pkg::PROD_W;
	localparam int CW  = tpi_pkg::CROSS_W;
	localparam int DW  = tpi_pkg::DEN_W;
	localparam int SW  = tpi_pkg::SUM_W;
	localparam int NW  = tpi_pkg::NUM_W;
	localparam int RW  = tpi_pkg::REM_W;
	localparam int QW  = tpi_pkg::QUO_W;
	localparam int LAT = tpi_pkg::LATENCY;

	logic en;
	logic [LAT-1:0] vld_s;

	logic signed [NB-1:0] n_in [3][3];
	logic signed [CB-1:0] d_in [3];

	logic signed [PW-1:0] pr_s1 [3][3][2];
	logic signed [NB-1:0] n0_s1 [3];
	logic signed [CB-1:0] d_s1  [3];

	logic signed [CW-1:0] cr_s2 [3][3];
	logic signed [NB-1:0] n0_s2 [3];
	logic signed [CB-1:0] d_s2  [3];

	logic signed [DW-1:0] dt_s3 [3];
	logic signed [SW-1:0] sp_s3 [3][3];

	logic signed [DW-1:0] den_s4;
	logic signed [SW-1:0] sum_s4 [3];

	logic [DW-1:0] den_mag;
	logic [SW-1:0] sum_mag [3];

	logic [NW-1:0] num_s5 [3];
	logic [DW-1:0] md_s5;
	logic          neg_s5 [3];
	logic          found_s5;

	logic [RW-1:0]  num_s6  [3];
	logic [DW-1:0]  md_s6;
	tpi_pkg::side_t side_s6 [3];

	logic [QW-1:0]  quo     [3];
	tpi_pkg::side_t side_dv [3];

	logic [CB-1:0] point_s [3];
	logic          found_s;

	// the whole pipeline advances unless a result is held at the output
	assign en            = ~m_axis_tvalid | m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], s_axis_tvalid};
		end
	end

	assign m_axis_tvalid = vld_s[LAT-1];

	// unpack the plane fields
	always_comb begin
		for (int p = 0; p < 3; p++) begin
			for (int k = 0; k < 3; k++) begin
				n_in[p][k] = s_axis_tdata[p * tpi_pkg::PLANE_W + k * NB +: NB];
			end
			d_in[p] = s_axis_tdata[p * tpi_pkg::PLANE_W + 3 * NB +: CB];
		end
	end

	// stage 1: the eighteen products of the three cross products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				for (int k = 0; k < 3; k++) begin
					pr_s1[c][k][0] <= n_in[(c + 1) % 3][(k + 1) % 3]
						* n_in[(c + 2) % 3][(k + 2) % 3];
					pr_s1[c][k][1] <= n_in[(c + 1) % 3][(k + 2) % 3]
						* n_in[(c + 2) % 3][(k + 1) % 3];
				end
			end
			n0_s1 <= n_in[0];
			d_s1  <= d_in;
		end
	end

	// stage 2: cross products n2 x n3, n3 x n1, n1 x n2
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				for (int k = 0; k < 3; k++) begin
					cr_s2[c][k] <= CW'(pr_s1[c][k][0]) - CW'(pr_s1[c][k][1]);
				end
			end
			n0_s2 <= n0_s1;
			d_s2  <= d_s1;
		end
	end

	// stage 3: terms of the triple product and of the three numerators
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				dt_s3[k] <= DW'(n0_s2[k]) * DW'(cr_s2[0][k]);
				for (int c = 0; c < 3; c++) begin
					sp_s3[k][c] <= SW'(d_s2[c]) * SW'(cr_s2[c][k]);
				end
			end
		end
	end

	// stage 4: sums
	always_ff @(posedge clk) begin
		if (en) begin
			den_s4 <= dt_s3[0] + dt_s3[1] + dt_s3[2];
			for (int k = 0; k < 3; k++) begin
				sum_s4[k] <= sp_s3[k][0] + sp_s3[k][1] + sp_s3[k][2];
			end
		end
	end

	// stage 5: magnitudes, scaled numerator plus half the divisor for rounding
	always_comb begin
		den_mag = den_s4[DW-1] ? DW'(-den_s4) : DW'(den_s4);
		for (int k = 0; k < 3; k++) begin
			sum_mag[k] = sum_s4[k][SW-1] ? SW'(-sum_s4[k]) : SW'(sum_s4[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			md_s5    <= den_mag;
			found_s5 <= den_s4 != '0;
			for (int k = 0; k < 3; k++) begin
				num_s5[k] <= (NW'(sum_mag[k]) << tpi_pkg::FRAC_BITS) + NW'(den_mag >> 1);
				neg_s5[k] <= sum_s4[k][SW-1] == den_s4[DW-1];
			end
		end
	end

	// stage 6: quotient of 2^QW or more saturates
	always_ff @(posedge clk) begin
		if (en) begin
			md_s6 <= md_s5;
			for (int k = 0; k < 3; k++) begin
				num_s6[k]        <= RW'(num_s5[k]);
				side_s6[k].neg   <= neg_s5[k];
				side_s6[k].ovf   <= RW'(num_s5[k]) >= (RW'(md_s5) << QW);
				side_s6[k].found <= found_s5;
			end
		end
	end

	// one divider per coordinate
	for (genvar k = 0; k < 3; k++) begin : g_div
		tpi_div u_div (
			.clk      (clk),
			.en       (en),
			.num_in   (num_s6[k]),
			.den_in   (md_s6),
			.side_in  (side_s6[k]),
			.quo      (quo[k]),
			.side_out (side_dv[k])
		);
	end

	// output register: sign, saturation, zero when no single point
	always_ff @(posedge clk) begin
		if (en) begin
			found_s <= side_dv[0].found;
			for (int k = 0; k < 3; k++) begin
				priority if (!side_dv[k].found) begin
					point_s[k] <= '0;
				end else if (side_dv[k].neg) begin
					if (side_dv[k].ovf || quo[k] > {1'b1, {(QW - 1){1'b0}}}) begin
						point_s[k] <= {1'b1, {(CB - 1){1'b0}}};
					end else begin
						point_s[k] <= CB'(-quo[k]);
					end
				end else begin
					if (side_dv[k].ovf || quo[k][QW-1]) begin
						point_s[k] <= {1'b0, {(CB - 1){1'b1}}};
					end else begin
						point_s[k] <= CB'(quo[k]);
					end
				end
			end
		end
	end

	assign m_axis_tdata = tpi_pkg::OUT_W'({point_s[2], point_s[1], point_s[0]});
	assign m_axis_tuser = found_s;

`ifndef ASSERT_OFF
	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("no-intersection result with nonzero point");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
		else $error("input taken while output stalled");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> vld_s[0])
		else $error("accepted transfer missing from first stage");
`endif

endmodule

// ----- bench/tb_three_plane_intersection.sv -----
// tb_three_plane_intersection: self-checking bench for the three-plane intersection
// depends on tpi_pkg and three_plane_intersection; random and directed plane triples

module tb_three_plane_intersection;
	import tpi_pkg::*;

	localparam int WIDE = 160;
	localparam int RAND_ITEMS = 1530;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] px;
		logic signed [COORD_BITS-1:0] py;
		logic signed [COORD_BITS-1:0] pz;
		logic found;
	} point_t;

	// golden point of three planes: exact sums, rounded and saturated quotient
	function automatic point_t solve_planes(input logic [IN_W-1:0] raw);
		logic signed [WIDE-1:0] n [3][3];
		logic signed [WIDE-1:0] d [3];
		logic signed [WIDE-1:0] c23 [3];
		logic signed [WIDE-1:0] c31 [3];
		logic signed [WIDE-1:0] c12 [3];
		logic signed [WIDE-1:0] den, s, ms, md, q;
		logic signed [WIDE-1:0] vals [3];
		logic signed [WIDE-1:0] hi_lim, lo_lim;
		logic negate;
		point_t r;
		int base, a, b;
		hi_lim = (WIDE'(1) <<< (COORD_BITS - 1)) - 1;
		lo_lim = -(WIDE'(1) <<< (COORD_BITS - 1));
		for (int p = 0; p < 3; p++) begin
			base = p * PLANE_W;
			for (int k = 0; k < 3; k++)
				n[p][k] = WIDE'($signed(raw[base + k*NORMAL_BITS +: NORMAL_BITS]));
			d[p] = WIDE'($signed(raw[base + 3*NORMAL_BITS +: COORD_BITS]));
		end
		for (int k = 0; k < 3; k++) begin
			a = (k + 1) % 3;
			b = (k + 2) % 3;
			c23[k] = n[1][a] * n[2][b] - n[1][b] * n[2][a];
			c31[k] = n[2][a] * n[0][b] - n[2][b] * n[0][a];
			c12[k] = n[0][a] * n[1][b] - n[0][b] * n[1][a];
		end
		den = n[0][0] * c23[0] + n[0][1] * c23[1] + n[0][2] * c23[2];
		r = '0;
		if (den == 0)
			return r;
		r.found = 1'b1;
		for (int k = 0; k < 3; k++) begin
			s = d[0] * c23[k] + d[1] * c31[k] + d[2] * c12[k];
			negate = (s < 0) == (den < 0);
			ms = (s < 0) ? -s : s;
			md = (den < 0) ? -den : den;
			q = ((ms <<< FRAC_BITS) + (md >>> 1)) / md;
			if (negate)
				q = -q;
			if (q > hi_lim)
				q = hi_lim;
			if (q < lo_lim)
				q = lo_lim;
			vals[k] = q;
		end
		r.px = vals[0][COORD_BITS-1:0];
		r.py = vals[1][COORD_BITS-1:0];
		r.pz = vals[2][COORD_BITS-1:0];
		return r;
	endfunction

	int mismatches = 0;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	// in-order store of expected points
	class point_board;
		point_t pending[$];
		int checked = 0;
		int misses = 0;

		function void note_planes(input logic [IN_W-1:0] raw);
			pending.push_back(solve_planes(raw));
		endfunction

		task check_point(input logic [OUT_W-1:0] data, input logic found);
			point_t want;
			if (pending.size() == 0) begin
				report_mismatch("result with nothing expected");
				return;
			end
			want = pending.pop_front();
			checked++;
			if (!want.found)
				misses++;
			if (found !== want.found)
				report_mismatch($sformatf("found %b want %b", found, want.found));
			if (data[0 +: COORD_BITS] !== want.px)
				report_mismatch($sformatf("x %h want %h", data[0 +: COORD_BITS], want.px));
			if (data[COORD_BITS +: COORD_BITS] !== want.py)
				report_mismatch($sformatf("y %h want %h",
					data[COORD_BITS +: COORD_BITS], want.py));
			if (data[2*COORD_BITS +: COORD_BITS] !== want.pz)
				report_mismatch($sformatf("z %h want %h",
					data[2*COORD_BITS +: COORD_BITS], want.pz));
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic m_axis_tuser;

	point_board board = new();
	logic quiet = 0;
	longint cycles = 0;

	three_plane_intersection u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// sample results and accepted inputs at the rising edge
	always @(posedge clk) begin
		cycles++;
		if (s_axis_tvalid && s_axis_tready)
			board.note_planes(s_axis_tdata);
		if (m_axis_tvalid && m_axis_tready)
			board.check_point(m_axis_tdata, m_axis_tuser);
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_three_plane_intersection: FAIL");
			$finish;
		end
	end

	// output side stalls, except through the quiet stretch
	always @(negedge clk) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= quiet || ($urandom_range(99) >= 9);
	end

	function automatic logic [NORMAL_BITS-1:0] rand_normal(input int mode);
		case (mode)
			0: return NORMAL_BITS'($urandom);
			1: return NORMAL_BITS'($signed($urandom_range(32)) - 16);
			default: return NORMAL_BITS'($signed($urandom_range(2 << FRAC_BITS)) - (1 << FRAC_BITS));
		endcase
	endfunction

	function automatic logic [COORD_BITS-1:0] rand_offset();
		case ($urandom_range(3))
			0: return COORD_BITS'($urandom);
			1: return COORD_BITS'($signed($urandom_range(2000)) - 1000);
			2: return COORD_BITS'($signed($urandom_range(1 << 22)) - (1 << 21));
			default: return $urandom_range(1) ? {1'b0, {(COORD_BITS-1){1'b1}}}
				: {1'b1, {(COORD_BITS-1){1'b0}}};
		endcase
	endfunction

	function automatic logic [IN_W-1:0] pack_planes(
		input logic [NORMAL_BITS-1:0] nv [3][3], input logic [COORD_BITS-1:0] dv [3]);
		logic [IN_W-1:0] w;
		w = '0;
		for (int p = 0; p < 3; p++) begin
			for (int k = 0; k < 3; k++)
				w[p*PLANE_W + k*NORMAL_BITS +: NORMAL_BITS] = nv[p][k];
			w[p*PLANE_W + 3*NORMAL_BITS +: COORD_BITS] = dv[p];
		end
		return w;
	endfunction

	// hold one item until it is taken, idling first at random
	task automatic send_planes(input logic [IN_W-1:0] w);
		while (!quiet && $urandom_range(99) < 9) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= w;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_fields(
		input logic [NORMAL_BITS-1:0] nv [3][3], input logic [COORD_BITS-1:0] dv [3]);
		send_planes(pack_planes(nv, dv));
	endtask

	logic [NORMAL_BITS-1:0] nv [3][3];
	logic [COORD_BITS-1:0] dv [3];
	logic [NORMAL_BITS-1:0] one_q, max_n, min_n;
	logic [COORD_BITS-1:0] max_d, min_d;

	initial begin
		one_q = NORMAL_BITS'(1 << FRAC_BITS);
		max_n = {1'b0, {(NORMAL_BITS-1){1'b1}}};
		min_n = {1'b1, {(NORMAL_BITS-1){1'b0}}};
		max_d = {1'b0, {(COORD_BITS-1){1'b1}}};
		min_d = {1'b1, {(COORD_BITS-1){1'b0}}};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// axis-aligned planes: point is minus the offsets
		nv = '{'{one_q, 0, 0}, '{0, one_q, 0}, '{0, 0, one_q}};
		dv = '{32'h0001_0000, 32'hFFFE_0000, 32'h0000_8000};
		send_fields(nv, dv);
		// extreme offsets: the minimum ones saturate their coordinates
		dv = '{min_d, max_d, min_d};
		send_fields(nv, dv);
		// tiny normals with extreme offsets overflow hard
		nv = '{'{1, 0, 0}, '{0, 1, 0}, '{0, 0, NORMAL_BITS'(-1)}};
		send_fields(nv, dv);
		dv = '{max_d, min_d, max_d};
		send_fields(nv, dv);
		// parallel planes: zero triple product
		nv = '{'{one_q, 0, 0}, '{one_q, 0, 0}, '{0, 0, one_q}};
		send_fields(nv, dv);
		// all normals zero, and all fields at extremes
		nv = '{'{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}};
		send_fields(nv, dv);
		nv = '{'{min_n, max_n, min_n}, '{max_n, min_n, max_n}, '{min_n, min_n, max_n}};
		send_fields(nv, dv);
		nv = '{'{min_n, 0, 0}, '{0, max_n, 0}, '{0, 0, min_n}};
		dv = '{1, 32'hFFFF_FFFF, 3};
		send_fields(nv, dv);
		// ties in rounding: half-unit results
		nv = '{'{NORMAL_BITS'(2 << FRAC_BITS), 0, 0}, '{0, one_q, 0}, '{0, 0, one_q}};
		dv = '{1, COORD_BITS'(-1), 3};
		send_fields(nv, dv);
		dv = '{32'hFFFF_FFFF, 0, 0};
		send_fields(nv, dv);
		// all-ones and all-zeros raw data
		send_planes('0);
		send_planes({IN_BITS{1'b1}});

		// random triples; a quiet stretch in the middle
		for (int i = 0; i < RAND_ITEMS; i++) begin
			quiet = (i >= 600 && i < 800);
			for (int p = 0; p < 3; p++) begin
				for (int k = 0; k < 3; k++)
					nv[p][k] = rand_normal($urandom_range(2));
				dv[p] = rand_offset();
			end
			// some dependent third planes give a zero triple product
			if ($urandom_range(9) == 0)
				nv[2] = nv[$urandom_range(1)];
			send_fields(nv, dv);
		end
		s_axis_tvalid <= 1'b0;
		quiet = 0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		$display("checked %0d points, %0d of them with no single intersection",
			board.checked, board.misses);
		if (mismatches == 0 && board.pending.size() == 0)
			$display("tb_three_plane_intersection: PASS");
		else
			$display("tb_three_plane_intersection: FAIL");
		$finish;
	end
endmodule

// ----- three_plane_intersection.f -----
design/tpi_pkg.sv
design/tpi_div.sv
design/three_plane_intersection.sv
bench/tb_three_plane_intersection.sv
